>>> src/button_gesture_fsm_unit_macros.svh
// assertion macros used by the button gesture detector sequencer
`ifndef BUTTON_GESTURE_FSM_UNIT_MACROS_SVH
`define BUTTON_GESTURE_FSM_UNIT_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define BGF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgf same-cycle check failed");

// antecedent in this cycle implies consequent in the next cycle
`define BGF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgf next-cycle check failed");

`endif

>>> src/bgf_pkg.sv
// shared types and constants of the button gesture detector
package bgf_pkg;

  // field widths
  localparam int REQ_W    = 3;
  localparam int BTN_W    = 3;
  localparam int TIME_W   = 32;
  localparam int LED_W    = 2;
  localparam int ACT_W    = 3;
  localparam int HOLD_W   = 16;
  localparam int OWNER_W  = 4;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int WIN_W    = 16;
  localparam int MODE_W   = 4;

  // default button count
  localparam int NUM_BUTTONS_DEF = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PRESS     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TICK      = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLR_HOLDS = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SET       = 3'd5;

  // visible button states
  localparam logic [LED_W-1:0] LED_OFF   = 2'd0;
  localparam logic [LED_W-1:0] LED_ARMED = 2'd1;
  localparam logic [LED_W-1:0] LED_ON    = 2'd2;
  localparam logic [LED_W-1:0] LED_ALT   = 2'd3;

  // activation methods
  localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MOMENTARY = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TOGGLE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DOUBLE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LONG      = 3'd4;

  localparam logic [OWNER_W-1:0] OWNER_NONE = 4'd15;
  localparam logic [HOLD_W-1:0]  HOLD_MAX   = 16'hFFFF;

  // mode bit positions within a button's nibble
  localparam int MODE_MOM  = 0;
  localparam int MODE_TOG  = 1;
  localparam int MODE_DBL  = 2;
  localparam int MODE_LONG = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_BITS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_HOLD   = 2'd3;

  // configuration reset values
  localparam logic [WIN_W-1:0] DOUBLE_WINDOW_RST = 16'd750;
  localparam logic [WIN_W-1:0] LONG_HOLD_RST     = 16'd2250;
  localparam logic [WIN_W-1:0] TOGGLE_HOLD_RST   = 16'd600;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } bgf_cmd_t;

endpackage

>>> src/button_gesture_fsm_unit.sv
// top level of the button gesture detector
//
// Usage:
//   in_* channel carries one item per request (type, button, timestamp,
//   new state); it is taken when in_valid is high and in_stall is low.
//   out_* channel returns exactly one result item per input item, taken
//   when out_valid is high and out_stall is low.
//   cfg_wr_en writes register cfg_index (0 mode bits, 1 double window,
//   2 long time, 3 toggle time) from cfg_wdata at the clock edge.
// Timing:
//   a taken item is captured, the execute step updates the table and
//   registers the result, and the result then waits on out_* until it
//   is taken; one item is in flight at a time, so no new item is taken
//   until the three-step sequencer (take, update table, deliver) is idle.
// Reset (rst_n low, synchronous): all buttons off, counters and stamps
//   zero, mode bits zero, windows back to their default values.
// Stall: while out_stall holds a result, it stays unchanged on out_*
//   and in_stall stays high, so no new item is taken.
module button_gesture_fsm_unit #(
  parameter int NUM_BUTTONS = bgf_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bgf_pkg::REQ_W-1:0]     in_req_type,
  input  logic [bgf_pkg::BTN_W-1:0]     in_button,
  input  logic [bgf_pkg::TIME_W-1:0]    in_now,
  input  logic [bgf_pkg::LED_W-1:0]     in_new_state,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_changed,
  output logic [bgf_pkg::LED_W-1:0]     out_led_state,
  output logic [bgf_pkg::ACT_W-1:0]     out_activation,
  output logic [bgf_pkg::HOLD_W-1:0]    out_hold_count
);
  import bgf_pkg::*;

  bgf_cmd_t cmd;

  // sequencer
  bgf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // state table and gesture logic
  bgf_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_req_type),
    .in_button      (in_button),
    .in_now         (in_now),
    .in_new_state   (in_new_state),
    .out_changed    (out_changed),
    .out_led_state  (out_led_state),
    .out_activation (out_activation),
    .out_hold_count (out_hold_count)
  );

endmodule

>>> src/bgf_ctrl.sv
// sequencer that takes one item, runs it and hands out its result
`include "button_gesture_fsm_unit_macros.svh"

module bgf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output bgf_pkg::bgf_cmd_t cmd
);
  import bgf_pkg::*;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_EXEC = 3'b010,
    CS_OUT  = 3'b100
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        in_acc;

  assign in_stall  = (state_r != CS_IDLE);
  assign out_valid = (state_r == CS_OUT);
  assign in_acc    = in_valid && !in_stall;

  assign cmd.capture = in_acc;
  assign cmd.execute = (state_r == CS_EXEC);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_acc) state_nxt = CS_EXEC;
      end
      CS_EXEC: begin
        state_nxt = CS_OUT;
      end
      CS_OUT: begin
        if (!out_stall) state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing checks
  `BGF_ASSERT_NEXT(a_acc_to_exec, clk, rst_n, in_acc, cmd.execute && !out_valid)
  `BGF_ASSERT_NEXT(a_exec_to_out, clk, rst_n, cmd.execute, out_valid && in_stall)
  `BGF_ASSERT_SAME(a_no_accept_busy, clk, rst_n, out_valid || cmd.execute, !cmd.capture)

endmodule

>>> src/bgf_datapath.sv
// per-button state table, configuration registers and gesture logic
module bgf_datapath #(
  parameter int NUM_BUTTONS = bgf_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bgf_pkg::bgf_cmd_t             cmd,
  input  logic                          cfg_wr_en,
  input  logic [bgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [bgf_pkg::REQ_W-1:0]     in_req_type,
  input  logic [bgf_pkg::BTN_W-1:0]     in_button,
  input  logic [bgf_pkg::TIME_W-1:0]    in_now,
  input  logic [bgf_pkg::LED_W-1:0]     in_new_state,
  output logic                          out_changed,
  output logic [bgf_pkg::LED_W-1:0]     out_led_state,
  output logic [bgf_pkg::ACT_W-1:0]     out_activation,
  output logic [bgf_pkg::HOLD_W-1:0]    out_hold_count
);
  import bgf_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // configuration registers
  logic [CFG_W-1:0] mode_r;
  logic [WIN_W-1:0] dwin_r, long_r, tog_r;

  // captured item
  logic [REQ_W-1:0]  req_r;
  logic [BTN_W-1:0]  btn_r;
  logic [TIME_W-1:0] now_r;
  logic [LED_W-1:0]  ns_r;

  // per-button table
  logic [LED_W-1:0]   st_r   [NUM_BUTTONS];
  logic [HOLD_W-1:0]  hold_r [NUM_BUTTONS];
  logic [TIME_W-1:0]  ps_r   [NUM_BUTTONS];
  logic [TIME_W-1:0]  rs_r   [NUM_BUTTONS];
  logic [BTN_W-1:0]   lr_r   [NUM_BUTTONS];
  logic [OWNER_W-1:0] own_r  [NUM_BUTTONS];
  logic [ACT_W-1:0]   meth_r [NUM_BUTTONS];

  // result registers
  logic              chg_r;
  logic [LED_W-1:0]  led_r;
  logic [ACT_W-1:0]  act_r;
  logic [HOLD_W-1:0] hcnt_r;

  // selected entry and its new values
  logic              in_range;
  logic [IDX_W-1:0]  idx;
  logic [MODE_W-1:0] m;
  logic [LED_W-1:0]   st, st_nxt;
  logic [HOLD_W-1:0]  hold, hold_inc, hold_nxt;
  logic [TIME_W-1:0]  ps, ps_nxt, rs, rs_nxt;
  logic [BTN_W-1:0]   lr, lr_nxt;
  logic [OWNER_W-1:0] own, own_nxt;
  logic [ACT_W-1:0]   meth, meth_nxt;
  logic               chg;
  logic [TIME_W-1:0]  held, gap, since;

  assign in_range = ({1'b0, btn_r} < (BTN_W+1)'(NUM_BUTTONS));
  assign idx      = btn_r[IDX_W-1:0];
  assign m        = mode_r[4*btn_r +: MODE_W];
  assign st       = st_r[idx];
  assign hold     = hold_r[idx];
  assign ps       = ps_r[idx];
  assign rs       = rs_r[idx];
  assign lr       = lr_r[idx];
  assign own      = own_r[idx];
  assign meth     = meth_r[idx];
  assign hold_inc = (hold == HOLD_MAX) ? hold : hold + 16'd1;
  assign held     = now_r - ps;
  assign gap      = ps - rs;
  assign since    = now_r - ps;

  // gesture rules for the addressed button
  always_comb begin
    st_nxt   = st;
    hold_nxt = hold;
    ps_nxt   = ps;
    rs_nxt   = rs;
    lr_nxt   = lr;
    own_nxt  = own;
    meth_nxt = meth;
    chg      = 1'b0;
    case (req_r)
      REQ_PRESS: begin
        hold_nxt = hold_inc;
        if (hold_inc == 16'd1) begin
          if (st == LED_ON || st == LED_ALT) begin
            ps_nxt   = '0;
            lr_nxt   = '0;
            st_nxt   = LED_OFF;
            meth_nxt = ACT_NONE;
            chg      = 1'b1;
          end else begin
            ps_nxt  = now_r;
            own_nxt = {1'b0, btn_r};
            if (m[MODE_MOM]) begin
              st_nxt   = LED_ON;
              meth_nxt = ACT_MOMENTARY;
              chg      = 1'b1;
            end else begin
              st_nxt = LED_ARMED;
            end
          end
        end else if (st == LED_ARMED) begin
          if (m[MODE_LONG]) begin
            if (held > {16'd0, long_r}) begin
              st_nxt   = LED_ALT;
              meth_nxt = ACT_LONG;
              chg      = 1'b1;
            end
          end else if (m[MODE_TOG]) begin
            if (held > {16'd0, tog_r}) begin
              st_nxt   = LED_ON;
              meth_nxt = ACT_TOGGLE;
              chg      = 1'b1;
            end
          end
        end
      end
      REQ_RELEASE: begin
        if (hold != '0) begin
          hold_nxt = '0;
          if (own == {1'b0, btn_r}) begin
            own_nxt = OWNER_NONE;
            if (m[MODE_MOM]) begin
              st_nxt   = LED_OFF;
              meth_nxt = ACT_NONE;
              chg      = 1'b1;
            end else if (st == LED_ARMED) begin
              if (m[MODE_DBL] && lr == btn_r && gap < {16'd0, dwin_r}) begin
                st_nxt   = LED_ALT;
                meth_nxt = ACT_DOUBLE;
                chg      = 1'b1;
              end else if (!m[MODE_DBL] && m[MODE_TOG]) begin
                st_nxt   = LED_ON;
                meth_nxt = ACT_TOGGLE;
                chg      = 1'b1;
              end else begin
                lr_nxt   = btn_r;
                rs_nxt   = now_r;
                st_nxt   = LED_OFF;
                meth_nxt = ACT_NONE;
                chg      = 1'b1;
              end
            end
          end
        end
      end
      REQ_TICK: begin
        if (st == LED_ARMED && hold == '0) begin
          if (m[MODE_TOG]) begin
            if (since > {16'd0, dwin_r}) begin
              st_nxt   = LED_ON;
              meth_nxt = ACT_TOGGLE;
              chg      = 1'b1;
            end
          end else if (m[MODE_DBL]) begin
            if (since > {16'd0, dwin_r}) begin
              ps_nxt   = '0;
              st_nxt   = LED_OFF;
              meth_nxt = ACT_NONE;
              chg      = 1'b1;
            end
          end else if (m[MODE_LONG]) begin
            ps_nxt   = '0;
            st_nxt   = LED_OFF;
            meth_nxt = ACT_NONE;
            chg      = 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        st_nxt   = ns_r;
        hold_nxt = '0;
        ps_nxt   = '0;
        rs_nxt   = '0;
        lr_nxt   = '0;
        own_nxt  = '0;
        meth_nxt = ACT_NONE;
      end
      REQ_CLR_HOLDS: begin
        hold_nxt = '0;
      end
      REQ_SET: begin
        st_nxt = ns_r;
      end
      default: begin
        chg = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      dwin_r <= DOUBLE_WINDOW_RST;
      long_r <= LONG_HOLD_RST;
      tog_r  <= TOGGLE_HOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE_BITS:     mode_r <= cfg_wdata;
        CFG_DOUBLE_WINDOW: dwin_r <= cfg_wdata[WIN_W-1:0];
        CFG_LONG_HOLD:     long_r <= cfg_wdata[WIN_W-1:0];
        CFG_TOGGLE_HOLD:   tog_r  <= cfg_wdata[WIN_W-1:0];
        default:           mode_r <= mode_r;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      btn_r <= in_button;
      now_r <= in_now;
      ns_r  <= in_new_state;
    end
  end

  // table update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        st_r[i]   <= LED_OFF;
        hold_r[i] <= '0;
        ps_r[i]   <= '0;
        rs_r[i]   <= '0;
        lr_r[i]   <= '0;
        own_r[i]  <= '0;
        meth_r[i] <= ACT_NONE;
      end
    end else if (cmd.execute) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (in_range && idx == IDX_W'(i)) begin
          st_r[i]   <= st_nxt;
          ps_r[i]   <= ps_nxt;
          rs_r[i]   <= rs_nxt;
          lr_r[i]   <= lr_nxt;
          own_r[i]  <= own_nxt;
          meth_r[i] <= meth_nxt;
        end
        // dropping all holds zeroes every counter, the addressed one included
        if (req_r == REQ_CLR_HOLDS) begin
          hold_r[i] <= '0;
        end else if (in_range && idx == IDX_W'(i)) begin
          hold_r[i] <= hold_nxt;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (in_range) begin
        chg_r  <= chg;
        led_r  <= st_nxt;
        act_r  <= meth_nxt;
        hcnt_r <= hold_nxt;
      end else begin
        chg_r  <= 1'b0;
        led_r  <= LED_OFF;
        act_r  <= ACT_NONE;
        hcnt_r <= '0;
      end
    end
  end

  assign out_changed    = chg_r;
  assign out_led_state  = led_r;
  assign out_activation = act_r;
  assign out_hold_count = hcnt_r;

endmodule

>>> tb/gesture_report_checker.sv
`timescale 1ns / 1ps
// result checker for the button gesture detector: predicts each result item and compares
module gesture_report_checker #(
  parameter int NUM_BUTTONS = bgf_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bgf_pkg::REQ_W-1:0]     in_req_type,
  input  logic [bgf_pkg::BTN_W-1:0]     in_button,
  input  logic [bgf_pkg::TIME_W-1:0]    in_now,
  input  logic [bgf_pkg::LED_W-1:0]     in_new_state,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_changed,
  input  logic [bgf_pkg::LED_W-1:0]     out_led_state,
  input  logic [bgf_pkg::ACT_W-1:0]     out_activation,
  input  logic [bgf_pkg::HOLD_W-1:0]    out_hold_count,
  output int                            mismatch_count,
  output int                            pending_reports
);
  import bgf_pkg::*;

  typedef struct packed {
    logic              changed;
    logic [LED_W-1:0]  led;
    logic [ACT_W-1:0]  act;
    logic [HOLD_W-1:0] hold;
  } report_t;

  // predicted copy of the configuration
  logic [CFG_W-1:0] mode_bits;
  logic [WIN_W-1:0] double_window;
  logic [WIN_W-1:0] long_hold_ms;
  logic [WIN_W-1:0] toggle_hold_ms;

  // predicted per-button table
  logic [LED_W-1:0]   btn_state  [NUM_BUTTONS];
  logic [HOLD_W-1:0]  hold_cnt   [NUM_BUTTONS];
  logic [TIME_W-1:0]  press_ms   [NUM_BUTTONS];
  logic [TIME_W-1:0]  release_ms [NUM_BUTTONS];
  logic [BTN_W-1:0]   last_rel   [NUM_BUTTONS];
  logic [OWNER_W-1:0] owner      [NUM_BUTTONS];
  logic [ACT_W-1:0]   method     [NUM_BUTTONS];

  report_t predicted_reports[$];

  function automatic void clear_button(input int b);
    btn_state[b]  = LED_OFF;
    hold_cnt[b]   = '0;
    press_ms[b]   = '0;
    release_ms[b] = '0;
    last_rel[b]   = '0;
    owner[b]      = '0;
    method[b]     = ACT_NONE;
  endfunction

  // one request against the predicted table, returns the result item it causes
  function automatic report_t step_buttons(input logic [REQ_W-1:0] req,
                                           input logic [BTN_W-1:0] b,
                                           input logic [TIME_W-1:0] now,
                                           input logic [LED_W-1:0] ns);
    logic [MODE_W-1:0] m;
    logic              hit;
    logic [TIME_W-1:0] held;
    report_t           r;
    int                i;
    hit = 1'b0;
    if (req == REQ_CLR_HOLDS) begin
      for (i = 0; i < NUM_BUTTONS; i++) hold_cnt[i] = '0;
    end
    if (int'(b) >= NUM_BUTTONS) begin
      return '0;
    end
    m = mode_bits[MODE_W*b +: MODE_W];
    case (req)
      REQ_PRESS: begin
        if (hold_cnt[b] != HOLD_MAX) hold_cnt[b] = hold_cnt[b] + 1'b1;
        if (hold_cnt[b] == 16'd1) begin
          // first press of a hold: an active button goes off, else arm or fire
          if (btn_state[b] == LED_ON || btn_state[b] == LED_ALT) begin
            press_ms[b]  = '0;
            last_rel[b]  = '0;
            btn_state[b] = LED_OFF;
            method[b]    = ACT_NONE;
            hit = 1'b1;
          end else begin
            press_ms[b] = now;
            owner[b]    = {1'b0, b};
            if (m[MODE_MOM]) begin
              btn_state[b] = LED_ON;
              method[b]    = ACT_MOMENTARY;
              hit = 1'b1;
            end else begin
              btn_state[b] = LED_ARMED;
            end
          end
        end else if (btn_state[b] == LED_ARMED) begin
          // held long enough for a long press or a held toggle
          held = now - press_ms[b];
          if (m[MODE_LONG]) begin
            if (held > {16'd0, long_hold_ms}) begin
              btn_state[b] = LED_ALT;
              method[b]    = ACT_LONG;
              hit = 1'b1;
            end
          end else if (m[MODE_TOG]) begin
            if (held > {16'd0, toggle_hold_ms}) begin
              btn_state[b] = LED_ON;
              method[b]    = ACT_TOGGLE;
              hit = 1'b1;
            end
          end
        end
      end
      REQ_RELEASE: begin
        if (hold_cnt[b] != '0) begin
          hold_cnt[b] = '0;
          if (owner[b] == {1'b0, b}) begin
            owner[b] = OWNER_NONE;
            if (m[MODE_MOM]) begin
              btn_state[b] = LED_OFF;
              method[b]    = ACT_NONE;
              hit = 1'b1;
            end else if (btn_state[b] == LED_ARMED) begin
              if (m[MODE_DBL] && last_rel[b] == b &&
                  (press_ms[b] - release_ms[b]) < {16'd0, double_window}) begin
                btn_state[b] = LED_ALT;
                method[b]    = ACT_DOUBLE;
              end else if (!m[MODE_DBL] && m[MODE_TOG]) begin
                btn_state[b] = LED_ON;
                method[b]    = ACT_TOGGLE;
              end else begin
                // plain release: remember it for a later double press
                last_rel[b]   = b;
                release_ms[b] = now;
                btn_state[b]  = LED_OFF;
                method[b]     = ACT_NONE;
              end
              hit = 1'b1;
            end
          end
        end
      end
      REQ_TICK: begin
        if (btn_state[b] == LED_ARMED && hold_cnt[b] == '0) begin
          held = now - press_ms[b];
          if (m[MODE_TOG]) begin
            if (held > {16'd0, double_window}) begin
              btn_state[b] = LED_ON;
              method[b]    = ACT_TOGGLE;
              hit = 1'b1;
            end
          end else if (m[MODE_DBL]) begin
            if (held > {16'd0, double_window}) begin
              press_ms[b]  = '0;
              btn_state[b] = LED_OFF;
              method[b]    = ACT_NONE;
              hit = 1'b1;
            end
          end else if (m[MODE_LONG]) begin
            press_ms[b]  = '0;
            btn_state[b] = LED_OFF;
            method[b]    = ACT_NONE;
            hit = 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        clear_button(b);
        btn_state[b] = ns;
      end
      REQ_SET: btn_state[b] = ns;
      default: ;
    endcase
    r.changed = hit;
    r.led     = btn_state[b];
    r.act     = method[b];
    r.hold    = hold_cnt[b];
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatch_count < 10) $display("%0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // watch both channels and the configuration port on every rising edge
  always @(posedge clk) begin
    report_t want;
    report_t got;
    int      b;
    if (!rst_n) begin
      mode_bits      = '0;
      double_window  = DOUBLE_WINDOW_RST;
      long_hold_ms   = LONG_HOLD_RST;
      toggle_hold_ms = TOGGLE_HOLD_RST;
      for (b = 0; b < NUM_BUTTONS; b++) clear_button(b);
      predicted_reports.delete();
      mismatch_count = 0;
    end else begin
      // result side first: it answers an older item
      if (out_valid && !out_stall) begin
        got = '{out_changed, out_led_state, out_activation, out_hold_count};
        if (predicted_reports.size() == 0) begin
          note_mismatch($sformatf(
            "result item with no item pending: changed=%0d led=%0d act=%0d hold=%0d",
            got.changed, got.led, got.act, got.hold));
        end else begin
          want = predicted_reports.pop_front();
          if (want.changed != got.changed || want.led != got.led ||
              want.act != got.act || want.hold != got.hold) begin
            note_mismatch($sformatf(
              "expected chg=%0d led=%0d act=%0d hold=%0d, got chg=%0d led=%0d act=%0d hold=%0d",
              want.changed, want.led, want.act, want.hold,
              got.changed, got.led, got.act, got.hold));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted_reports.push_back(
          step_buttons(in_req_type, in_button, in_now, in_new_state));
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MODE_BITS:     mode_bits      = cfg_wdata;
          CFG_DOUBLE_WINDOW: double_window  = cfg_wdata[WIN_W-1:0];
          CFG_LONG_HOLD:     long_hold_ms   = cfg_wdata[WIN_W-1:0];
          CFG_TOGGLE_HOLD:   toggle_hold_ms = cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end
    end
    pending_reports = predicted_reports.size();
  end

endmodule

>>> tb/button_gesture_fsm_unit_test.sv
`timescale 1ns / 1ps
// testbench top for the button gesture detector: stimulus, configuration phases and verdict
module button_gesture_fsm_unit_test;
  import bgf_pkg::*;

  // request codes the block ignores
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES       = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [REQ_W-1:0]     in_req_type;
  logic [BTN_W-1:0]     in_button;
  logic [TIME_W-1:0]    in_now;
  logic [LED_W-1:0]     in_new_state;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_changed;
  logic [LED_W-1:0]     out_led_state;
  logic [ACT_W-1:0]     out_activation;
  logic [HOLD_W-1:0]    out_hold_count;

  int mismatch_count;
  int pending_reports;

  // stimulus state
  bit                quiet;
  int                stall_left;
  int                items_sent;
  int unsigned       time_span;
  logic [TIME_W-1:0] clock_ms;
  logic [BTN_W-1:0]  last_btn;

  button_gesture_fsm_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_button      (in_button),
    .in_now         (in_now),
    .in_new_state   (in_new_state),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_changed    (out_changed),
    .out_led_state  (out_led_state),
    .out_activation (out_activation),
    .out_hold_count (out_hold_count)
  );

  gesture_report_checker u_report_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_button       (in_button),
    .in_now          (in_now),
    .in_new_state    (in_new_state),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_changed     (out_changed),
    .out_led_state   (out_led_state),
    .out_activation  (out_activation),
    .out_hold_count  (out_hold_count),
    .mismatch_count  (mismatch_count),
    .pending_reports (pending_reports)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("button_gesture_fsm_unit_test: FAIL");
    $finish;
  end

  // receiver back-pressure: runs of stall and no stall, mostly short
  always @(negedge clk) begin
    int r;
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 35);
      r = $urandom_range(0, 99);
      if (r < 80) stall_left = $urandom_range(0, 2);
      else if (r < 96) stall_left = $urandom_range(3, 10);
      else stall_left = $urandom_range(20, 40);
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // advance the millisecond clock by a step sized to the current windows
  function automatic logic [TIME_W-1:0] next_ms();
    if ($urandom_range(0, 19) == 0)
      clock_ms = clock_ms + $urandom_range(0, 2 * time_span + 2);
    else clock_ms = clock_ms + $urandom_range(0, time_span / 3 + 1);
    return clock_ms;
  endfunction

  // offer one item and hold it until taken
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [BTN_W-1:0] btn,
                           input logic [TIME_W-1:0] now, input logic [LED_W-1:0] ns);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_button    <= btn;
    in_now       <= now;
    in_new_state <= ns;
    do @(posedge clk); while (in_stall);
    if (req != REQ_SPARE_A && req != REQ_SPARE_B) items_sent++;
  endtask

  // stop sending and wait for every predicted result item
  task automatic drain_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports != 0) @(negedge clk);
  endtask

  // all four registers back to back; only called while the block is idle
  task automatic write_config(input logic [CFG_W-1:0] mode, input logic [WIN_W-1:0] dw,
                              input logic [WIN_W-1:0] lt, input logic [WIN_W-1:0] tt);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MODE_BITS;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_index <= CFG_DOUBLE_WINDOW;
    cfg_wdata <= {16'($urandom), dw};
    @(negedge clk);
    cfg_index <= CFG_LONG_HOLD;
    cfg_wdata <= {16'($urandom), lt};
    @(negedge clk);
    cfg_index <= CFG_TOGGLE_HOLD;
    cfg_wdata <= {16'($urandom), tt};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    time_span = dw;
    if (lt > time_span) time_span = lt;
    if (tt > time_span) time_span = tt;
  endtask

  // well-formed press / release / tick sequence on one button
  task automatic run_gesture();
    logic [BTN_W-1:0] b;
    int               presses;
    int               k;
    b = ($urandom_range(0, 99) < 40) ? last_btn : 3'($urandom);
    last_btn = b;
    presses = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    for (k = 0; k < presses; k++) send_item(REQ_PRESS, b, next_ms(), 2'($urandom));
    // dropped holds leave an armed button for the ticks to resolve
    if ($urandom_range(0, 99) < 15)
      send_item(REQ_CLR_HOLDS, 3'($urandom), next_ms(), 2'($urandom));
    if ($urandom_range(0, 9) != 0) send_item(REQ_RELEASE, b, next_ms(), 2'($urandom));
    for (k = $urandom_range(0, 2); k > 0; k--) send_item(REQ_TICK, b, next_ms(), 2'($urandom));
  endtask

  // any request, any button, sometimes an arbitrary timestamp
  task automatic run_noise();
    logic [TIME_W-1:0] t;
    t = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom) : next_ms();
    send_item(3'($urandom), 3'($urandom), t, 2'($urandom));
  endtask

  initial begin
    int phase;
    int target;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_req_type  = '0;
    in_button    = '0;
    in_now       = '0;
    in_new_state = '0;
    quiet        = 1'b0;
    stall_left   = 0;
    items_sent   = 0;
    time_span    = 2250;
    last_btn     = '0;
    clock_ms     = 32'hFFFF_0000 - $urandom_range(0, 65535);
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: a plain press and release arms and then drops
    send_item(REQ_PRESS, 3'd6, 32'd100, LED_OFF);
    send_item(REQ_RELEASE, 3'd6, 32'd200, LED_OFF);
    drain_reports();

    // one mode per button: momentary, toggle, double, long, double+toggle, long+toggle, none, all
    write_config(32'hF0A6_8421, 16'd750, 16'd2250, 16'd600);
    send_item(REQ_PRESS, 3'd0, 32'd1000, LED_OFF);
    send_item(REQ_PRESS, 3'd0, 32'd1010, LED_OFF);
    send_item(REQ_RELEASE, 3'd0, 32'd1020, LED_OFF);
    // arming press reports no change, then held past the toggle time
    send_item(REQ_PRESS, 3'd1, 32'd2000, LED_OFF);
    send_item(REQ_PRESS, 3'd1, 32'd2700, LED_OFF);
    send_item(REQ_RELEASE, 3'd1, 32'd2710, LED_OFF);
    send_item(REQ_PRESS, 3'd1, 32'd2800, LED_OFF);
    // double press inside the window
    send_item(REQ_PRESS, 3'd2, 32'd3000, LED_OFF);
    send_item(REQ_RELEASE, 3'd2, 32'd3100, LED_OFF);
    send_item(REQ_PRESS, 3'd2, 32'd3300, LED_OFF);
    send_item(REQ_RELEASE, 3'd2, 32'd3400, LED_OFF);
    // long press, then all holds dropped so the release is a no-op
    send_item(REQ_PRESS, 3'd3, 32'd4000, LED_OFF);
    send_item(REQ_PRESS, 3'd3, 32'd6300, LED_OFF);
    send_item(REQ_CLR_HOLDS, 3'd3, 32'd6400, LED_OFF);
    send_item(REQ_RELEASE, 3'd3, 32'd6500, LED_OFF);
    // ticks on buttons forced to armed
    send_item(REQ_SET, 3'd1, 32'd7000, LED_ARMED);
    send_item(REQ_TICK, 3'd1, 32'd8000, LED_OFF);
    send_item(REQ_SET, 3'd3, 32'd8100, LED_ARMED);
    send_item(REQ_TICK, 3'd3, 32'd8200, LED_OFF);
    // clear into alt-on, then a press turns it off
    send_item(REQ_CLEAR, 3'd7, 32'd8300, LED_ALT);
    send_item(REQ_PRESS, 3'd7, 32'hFFFF_FFFF, LED_ON);
    // long press across the timestamp wrap
    send_item(REQ_PRESS, 3'd5, 32'hFFFF_FF00, LED_OFF);
    send_item(REQ_PRESS, 3'd5, 32'h0000_0A00, LED_OFF);
    // ignored request codes
    send_item(REQ_SPARE_A, 3'd4, 32'h0000_0000, LED_ON);
    send_item(REQ_SPARE_B, 3'd0, 32'hFFFF_FFFF, LED_ALT);
    drain_reports();

    // random phases, each under its own settings
    for (phase = 0; phase < PHASES; phase++) begin
      quiet = (phase == 3);
      case (phase)
        0: write_config(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0);
        1: write_config(32'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: write_config(32'h0000_0000, 16'($urandom_range(0, 1500)),
                        16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)));
        default: write_config(32'($urandom), 16'($urandom_range(0, 1500)),
                              16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)));
      endcase
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        if ($urandom_range(0, 3) == 0) run_noise();
        else run_gesture();
        // sender holds off until every result item is back
        if ($urandom_range(0, 149) == 0) drain_reports();
      end
      drain_reports();
    end
    quiet = 1'b0;

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_reports == 0) begin
      $display("button_gesture_fsm_unit_test: PASS");
    end else begin
      $display("button_gesture_fsm_unit_test: FAIL");
    end
    $finish;
  end

endmodule
